[rtl/rstp_pkg.sv]
// Package for the record serial-type parser: shared types, codes and helpers.
// Used by the queue, back end, top level and testbench; depends on nothing else.
package rstp_pkg;

	localparam int MAX_COLUMNS_DEF = 64;
	localparam int QUEUE_DEPTH     = 4;

	// Result kind codes.
	localparam logic [2:0] KIND_DATA     = 3'd0;
	localparam logic [2:0] KIND_NULL     = 3'd1;
	localparam logic [2:0] KIND_CONST    = 3'd2;
	localparam logic [2:0] KIND_RESERVED = 3'd3;
	localparam logic [2:0] KIND_DAMAGED  = 3'd4;

	// Configuration register byte address.
	localparam logic [2:0] REG_COLUMN_COUNT = 3'd0;

	// One input item as it travels through the queue.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       record_last;
	} item_t;

	// One result item.
	typedef struct packed {
		logic [5:0]  column_index;
		logic [2:0]  kind;
		logic [7:0]  byte_value;
		logic        is_text;
		logic        column_end;
		logic        record_end;
		logic [15:0] bytes_used;
		logic        last;
	} result_t;

	// Queue to back end handshake.
	typedef struct packed {
		logic  valid;
		item_t item;
	} q_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HDR,
		ST_CHECK,
		ST_LOAD,
		ST_LOAD_CAP,
		ST_TAIL_RD,
		ST_TAIL_PUT,
		ST_FIN
	} state_t;

	// Payload length of a column with the given serial type.
	function automatic logic [31:0] col_size(input logic [31:0] t);
		logic [31:0] r;
		r = 32'd0;
		if (t >= 32'd1 && t <= 32'd4) begin
			r = t;
		end else if (t == 32'd5) begin
			r = 32'd6;
		end else if (t == 32'd6 || t == 32'd7) begin
			r = 32'd8;
		end else if (t >= 32'd12) begin
			r = (t - 32'd12) >> 1;
		end
		return r;
	endfunction

	// Text columns have an odd serial type of at least thirteen.
	function automatic logic text_of(input logic [31:0] t);
		return t[0] && (t >= 32'd13);
	endfunction

endpackage

[rtl/rstp_ram.sv]
// Generic single write, single read RAM with a registered read port.
// Depends on nothing.
module rstp_ram #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Storage and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/rstp_queue.sv]
// Front end of the parser: takes input items and holds them in a short queue.
// Depends on rstp_pkg.
module rstp_queue
	import rstp_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	input  item_t  in_item,
	output logic   in_stall,
	output q_out_t head,
	input  logic   pop
);

	localparam int PW = $clog2(QUEUE_DEPTH);

	item_t             slot_q [QUEUE_DEPTH];
	logic [PW-1:0]     wr_q;
	logic [PW-1:0]     rd_q;
	logic [PW:0]       count_q;
	logic              push;
	logic              do_pop;

	assign in_stall   = (count_q == (PW+1)'(QUEUE_DEPTH));
	assign push       = in_valid && !in_stall;
	assign head.valid = (count_q != '0);
	assign head.item  = slot_q[rd_q];
	assign do_pop     = pop && head.valid;

	// Item storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= in_item;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (PW+1)'(QUEUE_DEPTH))
		else $error("queue fill level above depth");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == (PW+1)'(QUEUE_DEPTH)) |-> !push)
		else $error("item written into a full queue");
	a_pop_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !push) |=> (count_q == $past(count_q) - 1'b1))
		else $error("pop did not lower the fill level");

endmodule

[rtl/rstp_back.sv]
// Back end of the parser: decodes serial types, cuts columns and drives results.
// Depends on rstp_pkg and rstp_ram.
module rstp_back
	import rstp_pkg::*;
#(
	parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [6:0] cfg_count,
	input  q_out_t     head,
	output logic       pop,
	output result_t    result,
	output logic       result_valid,
	input  logic       result_stall
);

	localparam int CW = $clog2(MAX_COLUMNS + 1);
	localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

	state_t        state_q, state_n;
	logic [7:0]    b_q;
	logic          r_q;
	logic          body_q;
	logic [CW-1:0] cc_q;
	logic [CW-1:0] active_q;
	logic [CW-1:0] ti_q;
	logic [CW-1:0] dec_q;
	logic [31:0]   acc_q;
	logic          ovf_q;
	logic [3:0]    vbc_q;
	logic [31:0]   br_q;
	logic [15:0]   cons_q;
	logic [31:0]   cur_type_q;
	logic          cur_ovf_q;
	logic          step_data_q;
	result_t       pend_q;
	logic          pend_v_q;
	result_t       out_q;
	logic          out_v_q;

	logic          ram_we;
	logic [AW-1:0] ram_raddr;
	logic [32:0]   ram_rdata;
	logic [31:0]   rd_type;
	logic          rd_ovf;

	logic [CW-1:0] eff_count;
	logic [CW-1:0] act_now;
	logic [15:0]   cons_inc;
	logic          shift8;
	logic          sat;
	logic [31:0]   acc_sh;
	logic [31:0]   acc_n;
	logic          ovf_n;
	logic          vdone;
	logic [CW-1:0] cc_inc;
	logic [31:0]   br_dec;
	logic          out_free;
	logic          can_put;
	logic          put_en;
	result_t       put_res;
	result_t       fin_res;
	logic          hdr_to_body;
	logic          col_live;
	logic          tail_dec;

	assign rd_type = ram_rdata[31:0];
	assign rd_ovf  = ram_rdata[32];

	// Serial types and their overflow flags, one entry per column.
	rstp_ram #(
		.WIDTH(33),
		.DEPTH(MAX_COLUMNS)
	) u_types (
		.clk  (clk),
		.we   (ram_we),
		.waddr(cc_q[AW-1:0]),
		.wdata({ovf_n, acc_n}),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Effective column count from the register.
	always_comb begin
		if (cfg_count == 7'd0) begin
			eff_count = CW'(1);
		end else if ({25'd0, cfg_count} > 32'(MAX_COLUMNS)) begin
			eff_count = CW'(MAX_COLUMNS);
		end else begin
			eff_count = CW'(cfg_count);
		end
	end

	// Shared datapath values.
	always_comb begin
		act_now     = (cc_q == '0 && vbc_q == 4'd0) ? eff_count : active_q;
		cons_inc    = (cons_q == 16'hFFFF) ? cons_q : cons_q + 16'd1;
		shift8      = (vbc_q >= 4'd8);
		sat         = shift8 ? (acc_q[31:24] != 8'd0) : (acc_q[31:25] != 7'd0);
		acc_sh      = shift8 ? {acc_q[23:0], b_q} : {acc_q[24:0], b_q[6:0]};
		acc_n       = sat ? 32'hFFFF_FFFF : acc_sh;
		ovf_n       = ((vbc_q == 4'd0) ? 1'b0 : ovf_q) | sat;
		vdone       = shift8 || !b_q[7];
		cc_inc      = cc_q + 1'b1;
		br_dec      = br_q - 32'd1;
		hdr_to_body = vdone && (cc_inc >= act_now);
		col_live    = (cc_q < active_q);
		tail_dec    = (ti_q < dec_q);
		out_free    = !out_v_q || !result_stall;
		can_put     = !pend_v_q || out_free;
		// Final result of an item carries the step and record end marks.
		fin_res            = pend_q;
		fin_res.last       = 1'b1;
		fin_res.record_end = r_q;
	end

	// Next state.
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (head.valid) begin
					state_n = body_q ? ST_CHECK : ST_HDR;
				end
			end
			ST_HDR: begin
				if (r_q) begin
					state_n = ST_TAIL_RD;
				end else if (hdr_to_body) begin
					state_n = ST_LOAD;
				end else begin
					state_n = ST_FIN;
				end
			end
			ST_CHECK: begin
				if (!col_live) begin
					state_n = ST_FIN;
				end else if (can_put) begin
					if (br_q == 32'd0) begin
						state_n = ST_LOAD;
					end else if (br_dec == 32'd0 || r_q) begin
						state_n = r_q ? ST_TAIL_RD : ST_LOAD;
					end else begin
						state_n = ST_FIN;
					end
				end
			end
			ST_LOAD:     state_n = ST_LOAD_CAP;
			ST_LOAD_CAP: state_n = step_data_q ? ST_FIN : ST_CHECK;
			ST_TAIL_RD:  state_n = (ti_q >= active_q) ? ST_FIN : ST_TAIL_PUT;
			ST_TAIL_PUT: state_n = can_put ? ST_TAIL_RD : ST_TAIL_PUT;
			ST_FIN:      state_n = (!pend_v_q || out_free) ? ST_IDLE : ST_FIN;
			default:     state_n = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer: result production, RAM access and queue pop.
	always_comb begin
		put_en               = 1'b0;
		put_res              = '0;
		put_res.column_index = 6'(cc_q);
		put_res.bytes_used   = cons_q;
		put_res.column_end   = 1'b1;
		ram_we               = 1'b0;
		ram_raddr            = cc_q[AW-1:0];
		pop                  = 1'b0;
		unique case (state_q)
			ST_IDLE: pop = head.valid;
			ST_HDR:  ram_we = vdone;
			ST_CHECK: begin
				if (col_live && can_put) begin
					put_en = 1'b1;
					if (br_q == 32'd0) begin
						// Zero-length column ahead of this byte.
						if (cur_type_q == 32'd0) begin
							put_res.kind = KIND_NULL;
						end else if (cur_type_q == 32'd8 || cur_type_q == 32'd9) begin
							put_res.kind       = KIND_CONST;
							put_res.byte_value = {7'd0, cur_type_q[0]};
						end else if (cur_type_q == 32'd10 || cur_type_q == 32'd11) begin
							put_res.kind = KIND_RESERVED;
						end else begin
							put_res.kind    = KIND_DATA;
							put_res.is_text = text_of(cur_type_q);
						end
					end else begin
						// Payload byte of the current column.
						put_res.bytes_used = cons_inc;
						put_res.byte_value = b_q;
						put_res.is_text    = text_of(cur_type_q);
						if (br_dec == 32'd0) begin
							put_res.kind = cur_ovf_q ? KIND_DAMAGED : KIND_DATA;
						end else if (r_q) begin
							put_res.kind = KIND_DAMAGED;
						end else begin
							put_res.kind       = cur_ovf_q ? KIND_DAMAGED : KIND_DATA;
							put_res.column_end = 1'b0;
						end
					end
				end
			end
			ST_TAIL_RD:  ram_raddr = ti_q[AW-1:0];
			ST_TAIL_PUT: begin
				ram_raddr            = ti_q[AW-1:0];
				put_en               = can_put;
				put_res.column_index = 6'(ti_q);
				if (tail_dec && rd_type == 32'd0) begin
					put_res.kind = KIND_NULL;
				end else begin
					put_res.kind    = KIND_DAMAGED;
					put_res.is_text = tail_dec && text_of(rd_type);
				end
			end
			ST_LOAD, ST_LOAD_CAP, ST_FIN: begin
			end
			default: begin
			end
		endcase
	end

	// Item and column payload registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && head.valid) begin
			b_q <= head.item.data_byte;
			r_q <= head.item.record_last;
		end
		if (state_q == ST_LOAD_CAP) begin
			cur_type_q <= rd_type;
			cur_ovf_q  <= rd_ovf;
		end
		if (put_en) begin
			pend_q <= put_res;
		end
		if (put_en && pend_v_q) begin
			out_q <= pend_q;
		end else if (state_q == ST_FIN && pend_v_q && out_free) begin
			out_q <= fin_res;
		end
	end

	// Control state of the record walk.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			body_q      <= 1'b0;
			cc_q        <= '0;
			active_q    <= CW'(1);
			ti_q        <= '0;
			dec_q       <= '0;
			acc_q       <= '0;
			ovf_q       <= 1'b0;
			vbc_q       <= '0;
			br_q        <= '0;
			cons_q      <= '0;
			step_data_q <= 1'b0;
			pend_v_q    <= 1'b0;
			out_v_q     <= 1'b0;
		end else begin
			state_q <= state_n;

			// Result staging: pending result and output register.
			if (put_en) begin
				pend_v_q <= 1'b1;
				if (pend_v_q) begin
					out_v_q <= 1'b1;
				end else if (!result_stall) begin
					out_v_q <= 1'b0;
				end
			end else if (state_q == ST_FIN && pend_v_q && out_free) begin
				pend_v_q <= 1'b0;
				out_v_q  <= 1'b1;
			end else if (!result_stall) begin
				out_v_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: step_data_q <= 1'b0;
				ST_HDR: begin
					// One varint byte of the header.
					step_data_q <= 1'b1;
					active_q    <= act_now;
					cons_q      <= cons_inc;
					ti_q        <= '0;
					if (vdone) begin
						acc_q <= '0;
						vbc_q <= '0;
						ovf_q <= 1'b0;
						if (hdr_to_body) begin
							body_q <= 1'b1;
							cc_q   <= '0;
							dec_q  <= act_now;
						end else begin
							cc_q  <= cc_inc;
							dec_q <= cc_inc;
						end
					end else begin
						acc_q <= acc_n;
						ovf_q <= ovf_n;
						vbc_q <= vbc_q + 4'd1;
						dec_q <= cc_q;
					end
				end
				ST_CHECK: begin
					if (col_live && can_put) begin
						if (br_q == 32'd0) begin
							cc_q <= cc_inc;
						end else begin
							cons_q <= cons_inc;
							br_q   <= br_dec;
							if (br_dec == 32'd0 || r_q) begin
								cc_q        <= cc_inc;
								step_data_q <= 1'b1;
								ti_q        <= cc_inc;
								dec_q       <= active_q;
							end
						end
					end
				end
				ST_LOAD_CAP: br_q <= col_live ? col_size(rd_type) : 32'd0;
				ST_TAIL_PUT: begin
					if (can_put) begin
						ti_q <= ti_q + 1'b1;
					end
				end
				ST_FIN: begin
					if ((!pend_v_q || out_free) && r_q) begin
						// Record over: start the next one in the header.
						body_q <= 1'b0;
						cc_q   <= '0;
						acc_q  <= '0;
						ovf_q  <= 1'b0;
						vbc_q  <= '0;
						br_q   <= '0;
						cons_q <= '0;
					end
				end
				ST_LOAD, ST_TAIL_RD: begin
				end
				default: begin
				end
			endcase
		end
	end

	assign result       = out_q;
	assign result_valid = out_v_q;

	a_cc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cc_q <= active_q)
		else $error("column counter beyond active column count");
	a_vbc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vbc_q <= 4'd8)
		else $error("varint longer than nine bytes");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (state_q == ST_IDLE))
		else $error("item taken while another is in work");
	a_fin_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && state_n == ST_IDLE) |=> !pend_v_q)
		else $error("pending result left after item end");

endmodule

[rtl/record_serial_type_parser.sv]
// Top level of the record serial-type parser: configuration port, front queue
// and back end. Depends on rstp_pkg, rstp_queue and rstp_back.
//
// Record bytes enter through a four-item queue; a sequencer behind it works on
// one item at a time and serial types are held in a RAM with one read port. A
// header byte uses the idle, header and finish states, and a payload byte the
// idle, check and finish states; the byte that ends the header or a column also
// uses the load states, which fetch the next column's type. Each zero-length
// column ahead of a byte adds the check and load states; on the final byte
// each column at or after the record end adds a tail read and put, and a last
// tail read closes the walk. Results pass through a pending stage and an output
// register; while the consumer stalls, the sequencer halts at its next result
// and the queue takes up to four further items before the input stalls. Column
// count is taken from the register at the first byte of each record.
module record_serial_type_parser
	import rstp_pkg::*;
#(
	parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        data_valid,
	output logic        data_stall,
	input  logic [7:0]  data_byte,
	input  logic        record_last,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [5:0]  column_index,
	output logic [2:0]  kind,
	output logic [7:0]  byte_value,
	output logic        is_text,
	output logic        column_end,
	output logic        record_end,
	output logic [15:0] bytes_used,
	output logic        last
);

	logic [6:0] column_count_q;
	item_t      in_item;
	q_out_t     head;
	logic       pop;
	result_t    res;

	// Configuration register.
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= 7'd1;
		end else if (psel && penable && pwrite && paddr == REG_COLUMN_COUNT) begin
			column_count_q <= pwdata[6:0];
		end
	end
	assign prdata = (paddr == REG_COLUMN_COUNT) ? {25'd0, column_count_q} : 32'd0;

	// Front queue.
	assign in_item.data_byte   = data_byte;
	assign in_item.record_last = record_last;

	rstp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(data_valid),
		.in_item (in_item),
		.in_stall(data_stall),
		.head    (head),
		.pop     (pop)
	);

	// Back end.
	rstp_back #(
		.MAX_COLUMNS(MAX_COLUMNS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_count   (column_count_q),
		.head        (head),
		.pop         (pop),
		.result      (res),
		.result_valid(result_valid),
		.result_stall(result_stall)
	);

	assign column_index = res.column_index;
	assign kind         = res.kind;
	assign byte_value   = res.byte_value;
	assign is_text      = res.is_text;
	assign column_end   = res.column_end;
	assign record_end   = res.record_end;
	assign bytes_used   = res.bytes_used;
	assign last         = res.last;

endmodule

[dv/tb_record_serial_type_parser.sv]
// Self-checking testbench for record_serial_type_parser: drives record bytes,
// predicts every result from its own model of the parser and compares them.
// Depends on rstp_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb_record_serial_type_parser;
	import rstp_pkg::*;

	localparam int NCOL      = 64;
	localparam int TAIL_WAIT = 300;
	localparam int LIMIT     = 400000;

	typedef struct {
		logic [7:0] b;
		logic       r;
	} rec_byte_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        data_valid = 1'b0;
	logic        data_stall;
	logic [7:0]  data_byte = '0;
	logic        record_last = 1'b0;
	logic        result_valid;
	logic        result_stall = 1'b1;
	logic [5:0]  column_index;
	logic [2:0]  kind;
	logic [7:0]  byte_value;
	logic        is_text, column_end, record_end, last;
	logic [15:0] bytes_used;

	record_serial_type_parser i_dut (.*);

	always #4 clk = ~clk;

	// Parser state as the testbench tracks it.
	logic [31:0] type_mem [NCOL];
	logic        type_ovf [NCOL];
	logic [6:0]  count_reg = 7'd1;
	int unsigned cols_live = 1;
	logic        in_payload = 1'b0;
	int unsigned col_ptr = 0;
	logic [31:0] acc = '0;
	int unsigned acc_bytes = 0;
	logic [31:0] left = '0;
	logic [15:0] used = '0;

	rec_byte_t   pending_bytes[$];
	result_t     expected_results[$];
	result_t     step_results[$];
	int          err_count = 0;
	logic        took = 1'b0;
	logic        no_idle = 1'b0;
	logic        hold_req = 1'b0;
	int          gap = 0, hold_cnt = 0, sgap = 0;
	int          gen_count = 0;

	function automatic int unsigned live_columns(input logic [6:0] c);
		int unsigned n;
		n = c;
		if (n == 0) n = 1;
		if (n > NCOL) n = NCOL;
		return n;
	endfunction

	function automatic logic [31:0] col_len(input logic [31:0] t);
		if (t >= 1 && t <= 4) return t;
		if (t == 5) return 6;
		if (t == 6 || t == 7) return 8;
		if (t >= 12) return t[0] ? (t - 13) / 2 : (t - 12) / 2;
		return 0;
	endfunction

	function automatic logic text_col(input int unsigned i);
		return type_mem[i][0] && type_mem[i] >= 13;
	endfunction

	task automatic put_result(input int unsigned col, input logic [2:0] k,
			input logic [7:0] v, input logic tx, input logic ce);
		result_t e;
		e = '0;
		e.column_index = col[5:0];
		e.kind = k;
		e.byte_value = v;
		e.is_text = tx;
		e.column_end = ce;
		e.bytes_used = used;
		step_results.insert(step_results.size(), e);
	endtask

	task automatic load_len();
		left = (col_ptr < cols_live) ? col_len(type_mem[col_ptr]) : 32'd0;
	endtask

	// Columns from the given one onwards start at or past the record end.
	task automatic after_end(input int unsigned from, input int unsigned decoded);
		for (int unsigned i = from; i < cols_live; i++) begin
			if (i < decoded && type_mem[i] == 0)
				put_result(i, KIND_NULL, 8'd0, 1'b0, 1'b1);
			else
				put_result(i, KIND_DAMAGED, 8'd0, i < decoded ? text_col(i) : 1'b0, 1'b1);
		end
	endtask

	// Work out the results that one accepted byte causes.
	task automatic parse_byte(input logic [7:0] b, input logic r);
		int unsigned sh, i;
		logic [31:0] bits;
		logic [2:0] k;
		step_results.delete();
		if (!in_payload) begin
			if (col_ptr == 0 && acc_bytes == 0) cols_live = live_columns(count_reg);
			if (used != 16'hFFFF) used++;
			if (col_ptr < cols_live) begin
				if (acc_bytes == 0) type_ovf[col_ptr] = 1'b0;
				sh = (acc_bytes >= 8) ? 8 : 7;
				bits = (sh == 8) ? {24'd0, b} : {25'd0, b[6:0]};
				if ((acc >> (32 - sh)) != 0) begin
					acc = 32'hFFFF_FFFF;
					type_ovf[col_ptr] = 1'b1;
				end else begin
					acc = (acc << sh) | bits;
				end
				if (sh == 8 || !b[7]) begin
					type_mem[col_ptr] = acc;
					acc = '0;
					acc_bytes = 0;
					col_ptr++;
					if (col_ptr >= cols_live) begin
						in_payload = 1'b1;
						col_ptr = 0;
						load_len();
					end
				end else begin
					acc_bytes++;
				end
			end
			if (r) after_end(0, in_payload ? cols_live : col_ptr);
		end else begin
			// Empty columns are reported ahead of the byte itself.
			while (col_ptr < cols_live && left == 0) begin
				case (type_mem[col_ptr])
					0: put_result(col_ptr, KIND_NULL, 8'd0, 1'b0, 1'b1);
					8: put_result(col_ptr, KIND_CONST, 8'd0, 1'b0, 1'b1);
					9: put_result(col_ptr, KIND_CONST, 8'd1, 1'b0, 1'b1);
					10, 11: put_result(col_ptr, KIND_RESERVED, 8'd0, 1'b0, 1'b1);
					default: put_result(col_ptr, KIND_DATA, 8'd0, text_col(col_ptr), 1'b1);
				endcase
				col_ptr++;
				load_len();
			end
			if (col_ptr < cols_live) begin
				i = col_ptr;
				k = type_ovf[i] ? KIND_DAMAGED : KIND_DATA;
				if (used != 16'hFFFF) used++;
				left--;
				if (left == 0 || r) begin
					put_result(i, left == 0 ? k : KIND_DAMAGED, b, text_col(i), 1'b1);
					col_ptr++;
					load_len();
				end else begin
					put_result(i, k, b, text_col(i), 1'b0);
				end
			end
			if (r) after_end(col_ptr, cols_live);
		end
		if (step_results.size() > 0) begin
			if (r) step_results[$].record_end = 1'b1;
			step_results[$].last = 1'b1;
		end
		if (r) begin
			in_payload = 1'b0;
			col_ptr = 0;
			acc = '0;
			acc_bytes = 0;
			left = '0;
			used = '0;
		end
		foreach (step_results[j])
			expected_results.insert(expected_results.size(), step_results[j]);
	endtask

	// Sample accepted bytes at the rising edge.
	always @(posedge clk) begin
		if (arst_n && data_valid && !data_stall) begin
			parse_byte(data_byte, record_last);
			took = 1'b1;
		end
	end

	// Sender: a new item or an idle burst at the falling edge.
	always @(negedge clk) begin
		rec_byte_t it;
		if (arst_n && (!data_valid || took)) begin
			took = 1'b0;
			if (gap > 0) begin
				gap--;
				data_valid <= 1'b0;
			end else if (pending_bytes.size() > 0 && !no_idle && $urandom_range(0, 9) == 0) begin
				gap = $urandom_range(1, 17) - 1;
				data_valid <= 1'b0;
			end else if (pending_bytes.size() > 0) begin
				it = pending_bytes.pop_front();
				data_valid <= 1'b1;
				data_byte <= it.b;
				record_last <= it.r;
			end else begin
				data_valid <= 1'b0;
			end
		end
	end

	// Receiver stall: random bursts, plus one long hold on request.
	always @(negedge clk) begin
		if (!arst_n) begin
			result_stall <= 1'b1;
		end else begin
			if (hold_req) begin
				hold_cnt = 600;
				hold_req = 1'b0;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				result_stall <= 1'b1;
			end else if (sgap > 0) begin
				sgap--;
				result_stall <= 1'b1;
			end else if (!no_idle && $urandom_range(0, 7) == 0) begin
				sgap = $urandom_range(1, 17) - 1;
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	// Compare each accepted result with the oldest expectation.
	always @(posedge clk) begin
		result_t e;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result: column %0d kind %0d", column_index, kind);
				err_count++;
			end else begin
				e = expected_results.pop_front();
				if (column_index !== e.column_index) begin
					$error("column_index: expected %0d, got %0d", e.column_index, column_index);
					err_count++;
				end
				if (kind !== e.kind) begin
					$error("kind: expected %0d, got %0d", e.kind, kind);
					err_count++;
				end
				if (byte_value !== e.byte_value) begin
					$error("byte_value: expected %0d, got %0d", e.byte_value, byte_value);
					err_count++;
				end
				if (is_text !== e.is_text) begin
					$error("is_text: expected %0d, got %0d", e.is_text, is_text);
					err_count++;
				end
				if (column_end !== e.column_end) begin
					$error("column_end: expected %0d, got %0d", e.column_end, column_end);
					err_count++;
				end
				if (record_end !== e.record_end) begin
					$error("record_end: expected %0d, got %0d", e.record_end, record_end);
					err_count++;
				end
				if (bytes_used !== e.bytes_used) begin
					$error("bytes_used: expected %0d, got %0d", e.bytes_used, bytes_used);
					err_count++;
				end
				if (last !== e.last) begin
					$error("last: expected %0d, got %0d", e.last, last);
					err_count++;
				end
			end
		end
	end

	// Watchdog.
	int cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("tb_record_serial_type_parser failed");
			$finish;
		end
	end

	task automatic add_byte(input logic [7:0] b, input logic r);
		rec_byte_t it;
		it.b = b;
		it.r = r;
		pending_bytes.insert(pending_bytes.size(), it);
		gen_count++;
	endtask

	// Big-endian varint with continuation bits.
	task automatic add_varint(input logic [31:0] v);
		logic [7:0] grp[$];
		do begin
			grp.push_front({1'b0, v[6:0]});
			v = v >> 7;
		end while (v != 0);
		foreach (grp[j]) add_byte(grp[j] | (j < grp.size() - 1 ? 8'h80 : 8'h00), 1'b0);
	endtask

	task automatic write_count(input logic [6:0] v);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= REG_COLUMN_COUNT;
		pwdata <= {25'd0, v};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		count_reg = v;
	endtask

	// Wait until every queued item is taken and every result has come.
	task automatic drain();
		wait (pending_bytes.size() == 0 && !data_valid);
		wait (expected_results.size() == 0);
		repeat (TAIL_WAIT) @(posedge clk);
	endtask

	// A well-formed record with random content; it may end early or run on.
	task automatic gen_record();
		int unsigned n, total, cut, pick;
		logic [31:0] t;
		logic [7:0] body[$];
		n = live_columns(count_reg);
		total = 0;
		for (int unsigned i = 0; i < n; i++) begin
			pick = $urandom_range(0, 19);
			if (pick == 0) begin
				repeat (8) add_byte(8'hFF, 1'b0);
				add_byte(8'($urandom_range(0, 255)), 1'b0);
				total += 3;
			end else begin
				t = (pick < 14) ? $urandom_range(0, 13) : $urandom_range(14, 60);
				add_varint(t);
				total += col_len(t);
			end
		end
		for (int unsigned i = 0; i < total; i++)
			body.insert(body.size(), 8'($urandom_range(0, 255)));
		pick = $urandom_range(0, 9);
		if (pick < 2 && total > 1) begin
			cut = $urandom_range(1, total - 1);
			while (body.size() > cut) void'(body.pop_back());
		end else if (pick < 4 || body.size() == 0) begin
			repeat ($urandom_range(1, 3)) body.insert(body.size(), 8'($urandom_range(0, 255)));
		end
		foreach (body[j]) add_byte(body[j], j == body.size() - 1);
	endtask

	task automatic gen_noise();
		int unsigned n;
		n = $urandom_range(1, 6);
		for (int unsigned i = 0; i < n; i++)
			add_byte(8'($urandom_range(0, 255)), i == n - 1 || $urandom_range(0, 4) == 0);
	endtask

	initial begin
		foreach (type_mem[i]) begin
			type_mem[i] = '0;
			type_ovf[i] = 1'b0;
		end
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: every serial type class, oversized types, cut records.
		write_count(7'd4);
		add_varint(0); add_varint(8); add_varint(9); add_varint(10);
		add_byte(8'h00, 1'b1);
		add_varint(11); add_varint(13); add_varint(15); add_varint(12);
		add_byte(8'hFF, 1'b0);
		add_byte(8'h00, 1'b1);
		repeat (8) add_byte(8'hFF, 1'b0);
		add_byte(8'hFF, 1'b0);
		add_varint(7); add_varint(14); add_varint(1);
		add_byte(8'hA5, 1'b0);
		add_byte(8'h5A, 1'b1);
		add_byte(8'h83, 1'b0);
		add_byte(8'h01, 1'b1);
		drain();
		write_count(7'd64);
		add_byte(8'h00, 1'b0);
		add_byte(8'h06, 1'b1);
		drain();
		write_count(7'd0);
		add_varint(5);
		add_byte(8'h7F, 1'b0);
		add_byte(8'h80, 1'b0);
		add_byte(8'h01, 1'b1);
		drain();
		write_count(7'd127);
		add_byte(8'h81, 1'b1);
		drain();

		// Random phases; the first holds the receiver off for a long stretch.
		for (int ph = 0; gen_count < 115; ph++) begin
			write_count(($urandom_range(0, 5) == 0) ? 7'($urandom_range(0, 8))
				: 7'($urandom_range(1, 6)));
			if (ph == 0) hold_req = 1'b1;
			if (gen_count > 90) no_idle = 1'b1;
			repeat ($urandom_range(1, 2)) begin
				if ($urandom_range(0, 4) == 0) gen_noise();
				else gen_record();
			end
			drain();
		end
		write_count(7'd1);
		if (err_count == 0) begin
			$display("tb_record_serial_type_parser passed");
		end else begin
			$display("tb_record_serial_type_parser failed");
		end
		$finish;
	end

endmodule
